FILE: rtl/core/ntd_pkg.sv
// ntd_pkg: shared types and constants for the named table directory.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
package ntd_pkg;

  // Field widths fixed by the interface
  localparam int KEY_WORDS   = 4;
  localparam int KEY_BITS    = 64 * KEY_WORDS;
  localparam int REC_W       = 16;
  localparam int OFF_W       = 31;
  localparam int STAT_W      = 3;
  localparam int HASH_W      = 32;

  localparam logic [HASH_W-1:0] HASH_START  = 32'd5381;
  localparam logic [OFF_W-1:0]  STORE_RESET = 31'd1048576;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Main sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HEAD, S_LINK, S_NAME, S_CMP, S_MUL, S_MISS, S_WR, S_DONE
  } seq_state_t;

  // Hash unit states
  typedef enum logic [1:0] {H_IDLE, H_BYTE, H_MOD, H_DONE} hash_state_t;

  // Hash unit handshake towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } hash_stat_t;

endpackage

FILE: rtl/core/ntd_hash.sv
// ntd_hash: byte-serial djb2 hash with name normalisation, then a
// remainder by BUCKETS through a reciprocal multiply. Depends on ntd_pkg.
`timescale 1ns / 1ps
module ntd_hash #(
  parameter int NAME_BYTES = 32,
  parameter int BUCKETS    = 61
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ntd_pkg::KEY_BITS-1:0] key_raw,
  output ntd_pkg::hash_stat_t          stat,
  output logic [ntd_pkg::KEY_BITS-1:0] key_norm,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RL = $clog2(BUCKETS);
  localparam logic [4:0]  NB_LAST = 5'(NAME_BYTES - 1);
  // ceil(2^(32+RL) / BUCKETS): exact quotient for any 32-bit hash
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + RL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [31:0] DIVC  = 32'(BUCKETS);

  ntd_pkg::hash_state_t state, state_next;
  logic [4:0]                 idx;
  logic [ntd_pkg::HASH_W-1:0] h;
  logic [31:0]                quot;
  logic [BW-1:0]              rem;
  logic [7:0]                 byte_cur;
  logic                       name_end;
  logic [64:0]                prod;
  logic [31:0]                diff;

  assign byte_cur = key_raw[{idx, 3'b000} +: 8];
  assign name_end = (idx == NB_LAST) || (byte_cur == 8'd0);
  assign prod     = 65'(h) * 65'(RECIP);
  assign diff     = h - quot * DIVC;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ntd_pkg::H_IDLE: if (start) state_next = ntd_pkg::H_BYTE;
      ntd_pkg::H_BYTE: if (name_end) state_next = ntd_pkg::H_MOD;
      ntd_pkg::H_MOD:  if (idx == 5'd1) state_next = ntd_pkg::H_DONE;
      ntd_pkg::H_DONE: state_next = ntd_pkg::H_IDLE;
      default:         state_next = ntd_pkg::H_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat.busy = (state != ntd_pkg::H_IDLE);
    stat.done = (state == ntd_pkg::H_DONE);
  end

  assign bucket = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntd_pkg::H_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: hash one byte per cycle, then the quotient and then the remainder
  always_ff @(posedge clk) begin
    case (state)
      ntd_pkg::H_IDLE: begin
        if (start) begin
          idx      <= 5'd0;
          h        <= ntd_pkg::HASH_START;
          rem      <= '0;
          key_norm <= '0;
        end
      end
      ntd_pkg::H_BYTE: begin
        if (name_end) begin
          idx <= 5'd0;
        end else begin
          key_norm[{idx, 3'b000} +: 8] <= byte_cur;
          h   <= {h[ntd_pkg::HASH_W-6:0], 5'd0} + h + {24'd0, byte_cur};
          idx <= idx + 5'd1;
        end
      end
      ntd_pkg::H_MOD: begin
        if (idx == 5'd0) begin
          quot <= 32'(prod >> (32 + RL));
        end else begin
          rem <= diff[BW-1:0];
        end
        idx <= idx + 5'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/ntd_entry_mem.sv
// ntd_entry_mem: entry stores (names, links, sizes, counts, offsets),
// one write and one registered read each. Depends on ntd_pkg.
`timescale 1ns / 1ps
module ntd_entry_mem #(
  parameter int MAX_TABLES = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [((MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1)-1:0] wr_e,
  input  logic [$clog2(MAX_TABLES+1)-1:0]  wr_link,
  input  logic [ntd_pkg::REC_W-1:0]        wr_size,
  input  logic [ntd_pkg::REC_W-1:0]        wr_count,
  input  logic [ntd_pkg::OFF_W-1:0]        wr_off,
  input  logic                             name_we,
  input  logic [1:0]                       name_ww,
  input  logic [63:0]                      name_wd,
  input  logic [((MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1)-1:0] rd_e,
  input  logic [1:0]                       rd_w,
  output logic [63:0]                      name_q,
  output logic [$clog2(MAX_TABLES+1)-1:0]  link_q,
  output logic [ntd_pkg::REC_W-1:0]        size_q,
  output logic [ntd_pkg::REC_W-1:0]        count_q,
  output logic [ntd_pkg::OFF_W-1:0]        off_q
);

  localparam int LW = $clog2(MAX_TABLES + 1);

  logic [63:0]               names   [MAX_TABLES*ntd_pkg::KEY_WORDS];
  logic [LW-1:0]             links   [MAX_TABLES];
  logic [ntd_pkg::REC_W-1:0] sizes   [MAX_TABLES];
  logic [ntd_pkg::REC_W-1:0] counts  [MAX_TABLES];
  logic [ntd_pkg::OFF_W-1:0] offsets [MAX_TABLES];

  // Name words, four per entry
  always_ff @(posedge clk) begin
    if (name_we) begin
      names[{wr_e, name_ww}] <= name_wd;
    end
    name_q <= names[{rd_e, rd_w}];
  end

  // Per-entry header fields
  always_ff @(posedge clk) begin
    if (we) begin
      links[wr_e]   <= wr_link;
      sizes[wr_e]   <= wr_size;
      counts[wr_e]  <= wr_count;
      offsets[wr_e] <= wr_off;
    end
    link_q  <= links[rd_e];
    size_q  <= sizes[rd_e];
    count_q <= counts[rd_e];
    off_q   <= offsets[rd_e];
  end

endmodule

FILE: rtl/core/named_table_directory.sv
// named_table_directory: top level, sequencer, bucket heads and counters.
// Depends on ntd_pkg, ntd_hash and ntd_entry_mem.
`timescale 1ns / 1ps
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tuser cmd; tdata key words, size, count
//  m_*       out  m_tvalid / m_tready       tdata status, size, count, offset, used
//  APB       in   psel penable pwrite pready store_size at byte address 0
//
// One transaction goes through an accept, hashing and remainder, a bucket head
// read, then per chain entry visited a link step followed by a read and a compare
// per name word, then the hand-over of the result; an insert adds a multiply, a
// space check and the entry write before the hand-over.
// Reset clears the bucket valid bits and counters at once; no sweep.
// s_tready is high only while the sequencer is idle; a stalled result sits
// in the output register and does not block the next input.
module named_table_directory #(
  parameter int MAX_TABLES         = 64,
  parameter int BUCKETS            = 61,
  parameter int NAME_BYTES         = 32,
  parameter int ENTRY_HEADER_BYTES = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // key_word0..3, record_size, record_count
  input  logic         s_tuser,  // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // status, found_record_size, found_record_count,
                                 // data_offset, used_bytes, zero pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int EW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int LW = $clog2(MAX_TABLES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [30:0] DIR_HEAD = 31'(8 + 4 * BUCKETS);
  localparam logic [32:0] HDR      = 33'(ENTRY_HEADER_BYTES);
  localparam logic [LW-1:0] MAXT   = LW'(MAX_TABLES);

  ntd_pkg::seq_state_t state, state_next;

  logic [30:0]  store_size;
  logic [30:0]  bytes_in_use;
  logic [LW-1:0] tables_in_use;

  // Latched transaction
  logic [ntd_pkg::KEY_BITS-1:0] key_raw;
  logic        cmd;
  logic [15:0] rs, rc;

  // Hash unit
  ntd_pkg::hash_stat_t          hstat;
  logic [ntd_pkg::KEY_BITS-1:0] key_norm;
  logic [BW-1:0]                bucket;

  // Bucket heads: memory plus valid bits
  logic [LW-1:0] heads [BUCKETS];
  logic [BUCKETS-1:0] head_vld;
  logic [LW-1:0] head_q;
  logic          head_vq;
  logic          head_we;

  // Walk state
  logic [LW-1:0] link;
  logic [EW-1:0] cur_e;
  logic [1:0]    w;
  logic [31:0]   prod;
  logic [32:0]   total;
  logic [30:0]   left;

  // Entry memory ports
  logic [63:0]   name_q;
  logic [LW-1:0] link_q;
  logic [15:0]   size_q, count_q;
  logic [30:0]   off_q;
  logic [EW-1:0] new_e;
  logic          ent_we, name_we;

  // Result
  logic [2:0]  res_status;
  logic [15:0] res_size, res_count;
  logic [30:0] res_off;

  logic link_end, out_free, name_eq, bad_args, no_room;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, store_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      store_size <= ntd_pkg::STORE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      store_size <= pwdata[30:0];
    end
  end

  ntd_hash #(.NAME_BYTES(NAME_BYTES), .BUCKETS(BUCKETS)) u_hash (
    .clk(clk), .rst(rst), .start(state == ntd_pkg::S_HASH && !hstat.busy),
    .key_raw(key_raw), .stat(hstat), .key_norm(key_norm), .bucket(bucket)
  );

  assign new_e   = tables_in_use[EW-1:0];
  assign ent_we  = (state == ntd_pkg::S_WR) && (w == 2'd0);
  assign name_we = (state == ntd_pkg::S_WR);
  assign head_we = ent_we;

  ntd_entry_mem #(.MAX_TABLES(MAX_TABLES)) u_mem (
    .clk(clk), .we(ent_we), .wr_e(new_e),
    .wr_link(head_vq ? head_q : '0), .wr_size(rs), .wr_count(rc),
    .wr_off(31'({1'b0, bytes_in_use} + HDR[31:0])),
    .name_we(name_we), .name_ww(w), .name_wd(key_norm[{w, 6'd0} +: 64]),
    .rd_e(cur_e), .rd_w(w),
    .name_q(name_q), .link_q(link_q), .size_q(size_q), .count_q(count_q),
    .off_q(off_q)
  );

  // Bucket head memory, registered read at the current bucket
  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[bucket] <= tables_in_use + LW'(1);
    end
    head_q <= heads[bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      head_vq  <= 1'b0;
    end else begin
      if (head_we) head_vld[bucket] <= 1'b1;
      head_vq <= head_vld[bucket];
    end
  end

  // Decisions
  assign link_end = (link == '0) || (link > tables_in_use);
  assign name_eq  = (name_q == key_norm[{w, 6'd0} +: 64]);
  assign total    = {1'b0, prod} + HDR;
  assign left     = (store_size > bytes_in_use) ? store_size - bytes_in_use : 31'd0;
  assign bad_args = (rs == 16'd0) || (rc == 16'd0);
  assign no_room  = (total > {2'b00, left}) || (tables_in_use >= MAXT);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ntd_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ntd_pkg::S_IDLE: if (s_tvalid) state_next = ntd_pkg::S_HASH;
      ntd_pkg::S_HASH: if (hstat.done) state_next = ntd_pkg::S_HEAD;
      ntd_pkg::S_HEAD: state_next = ntd_pkg::S_LINK;
      ntd_pkg::S_LINK: begin
        if (!link_end) state_next = ntd_pkg::S_NAME;
        else if (cmd == ntd_pkg::CMD_LOOKUP) state_next = ntd_pkg::S_DONE;
        else state_next = ntd_pkg::S_MUL;
      end
      ntd_pkg::S_NAME: state_next = ntd_pkg::S_CMP;
      ntd_pkg::S_CMP: begin
        if (!name_eq) state_next = ntd_pkg::S_LINK;
        else if (w == 2'd3) state_next = ntd_pkg::S_DONE;
        else state_next = ntd_pkg::S_NAME;
      end
      ntd_pkg::S_MUL:  state_next = ntd_pkg::S_MISS;
      ntd_pkg::S_MISS: begin
        if (bad_args || no_room) state_next = ntd_pkg::S_DONE;
        else state_next = ntd_pkg::S_WR;
      end
      ntd_pkg::S_WR:   if (w == 2'd3) state_next = ntd_pkg::S_DONE;
      ntd_pkg::S_DONE: if (out_free) state_next = ntd_pkg::S_IDLE;
      default:         state_next = ntd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tables_in_use <= '0;
      bytes_in_use  <= DIR_HEAD;
    end else if (state == ntd_pkg::S_WR && w == 2'd3) begin
      tables_in_use <= tables_in_use + LW'(1);
      bytes_in_use  <= bytes_in_use + total[30:0];
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      ntd_pkg::S_IDLE: begin
        key_raw    <= s_tdata[255:0];
        rs         <= s_tdata[271:256];
        rc         <= s_tdata[287:272];
        cmd        <= s_tuser;
        res_status <= ntd_pkg::ST_NOT_FOUND;
        res_size   <= '0;
        res_count  <= '0;
        res_off    <= '0;
      end
      ntd_pkg::S_HEAD: link <= head_vq ? head_q : '0;
      ntd_pkg::S_LINK: begin
        cur_e <= EW'(link - LW'(1));
        w     <= 2'd0;
      end
      ntd_pkg::S_CMP: begin
        if (!name_eq) begin
          link <= link_q;
        end else if (w == 2'd3) begin
          res_status <= (cmd == ntd_pkg::CMD_LOOKUP) ? ntd_pkg::ST_OK
                                                     : ntd_pkg::ST_EXISTS;
          res_size   <= size_q;
          res_count  <= count_q;
          res_off    <= off_q;
        end else begin
          w <= w + 2'd1;
        end
      end
      ntd_pkg::S_MUL: prod <= rs * rc;
      ntd_pkg::S_MISS: begin
        w <= 2'd0;
        if (bad_args) res_status <= ntd_pkg::ST_INVALID;
        else if (no_room) res_status <= ntd_pkg::ST_NO_SPACE;
      end
      ntd_pkg::S_WR: begin
        w <= w + 2'd1;
        if (w == 2'd0) begin
          res_status <= ntd_pkg::ST_OK;
          res_size   <= rs;
          res_count  <= rc;
          res_off    <= 31'({1'b0, bytes_in_use} + HDR[31:0]);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ntd_pkg::S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ntd_pkg::S_DONE && out_free) begin
      m_tdata <= {7'd0, bytes_in_use, res_off, res_count, res_size, res_status};
    end
  end

endmodule

FILE: rtl/core/ntd_checker.sv
// ntd_checker: port-level assertions for named_table_directory, bound in.
// Depends on ntd_pkg and the top level's ports.
`timescale 1ns / 1ps
module ntd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);

  // Nothing emerges straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // One transaction at a time: busy after accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Status within its codes; success carries a table
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ntd_pkg::ST_NOT_FOUND) &&
                 ((m_tdata[2:0] != ntd_pkg::ST_OK) || (m_tdata[65:35] != 31'd0)))
    else $error("bad result status or empty table on success");

endmodule

bind named_table_directory ntd_checker u_ntd_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: bench/tb_named_table_directory.sv
// tb_named_table_directory: self-checking bench for the named table directory.
// Depends on ntd_pkg and named_table_directory; transactions are predicted in place.
`timescale 1ns / 1ps
module tb_named_table_directory;

  localparam int MAX_TAB   = 64;
  localparam int NBUCKET   = 61;
  localparam int ENTRY_HDR = 48;
  localparam int HEAD_SIZE = 252;
  localparam int POOL_N    = 40;
  localparam int LIMIT     = 10000000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] ADDR_STORE_SIZE = 3'd0;

  typedef struct packed {
    logic [ntd_pkg::STAT_W-1:0] status;
    logic [ntd_pkg::REC_W-1:0]  rsize;
    logic [ntd_pkg::REC_W-1:0]  rcount;
    logic [ntd_pkg::OFF_W-1:0]  offset;
    logic [ntd_pkg::OFF_W-1:0]  used;
  } outcome_t;

  typedef struct {
    logic            cmd;
    logic [255:0]    name;
    logic [15:0]     rsize;
    logic [15:0]     rcount;
    bit              fixed;
    logic [2:0]      status;
    logic [30:0]     used;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;  // key_word0..3, record_size, record_count
  logic         s_tuser = 1'b0;  // cmd
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;  // status, size, count, offset, used, zero pad
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  named_table_directory uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directory shadow
  logic [30:0]  dir_store_size;
  logic [6:0]   dir_heads [NBUCKET];
  logic [255:0] dir_names [MAX_TAB];
  logic [6:0]   dir_links [MAX_TAB];
  logic [15:0]  dir_sizes [MAX_TAB];
  logic [15:0]  dir_counts[MAX_TAB];
  logic [30:0]  dir_offs  [MAX_TAB];
  int unsigned  dir_tables;
  logic [30:0]  dir_used;
  outcome_t     dir_pending[$];

  int   errors = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;
  bit   cur_fixed = 1'b0;
  logic [2:0]  cur_status = '0;
  logic [30:0] cur_used = '0;
  row_t directed[$];
  logic [255:0] pool[POOL_N];

  // Normalise a name (stop at first zero, byte 31 ignored) and hash it to a bucket
  function automatic int name_bucket(input logic [255:0] raw, output logic [255:0] key);
    logic [31:0] h;
    logic [7:0]  b;
    h = ntd_pkg::HASH_START;
    key = '0;
    for (int i = 0; i < 31; i++) begin
      b = raw[i*8 +: 8];
      if (b == 8'd0) break;
      key[i*8 +: 8] = b;
      h = h * 32'd33 + {24'd0, b};
    end
    return int'(h % NBUCKET);
  endfunction

  function automatic outcome_t dir_apply(input logic cmd, input logic [255:0] raw,
                                         input logic [15:0] rs, input logic [15:0] rc);
    logic [255:0] key;
    int           bkt;
    int unsigned  link, hit, e;
    logic [63:0]  total, left;
    outcome_t     o;
    bkt = name_bucket(raw, key);
    link = dir_heads[bkt];
    hit = 0;
    for (int s = 0; s < MAX_TAB; s++) begin
      if (link == 0 || link > dir_tables) break;
      if (dir_names[link-1] == key) begin
        hit = link;
        break;
      end
      link = dir_links[link-1];
    end
    o = '0;
    if (hit != 0) begin
      o.status = (cmd == ntd_pkg::CMD_LOOKUP) ? ntd_pkg::ST_OK : ntd_pkg::ST_EXISTS;
      o.rsize  = dir_sizes[hit-1];
      o.rcount = dir_counts[hit-1];
      o.offset = dir_offs[hit-1];
    end else if (cmd == ntd_pkg::CMD_LOOKUP) begin
      o.status = ntd_pkg::ST_NOT_FOUND;
    end else begin
      total = 64'(ENTRY_HDR) + 64'(rs) * 64'(rc);
      left  = (dir_store_size > dir_used) ? 64'(dir_store_size - dir_used) : 64'd0;
      if (rs == 0 || rc == 0) begin
        o.status = ntd_pkg::ST_INVALID;
      end else if (total > left || dir_tables >= MAX_TAB) begin
        o.status = ntd_pkg::ST_NO_SPACE;
      end else begin
        e = dir_tables;
        dir_names[e]  = key;
        dir_links[e]  = dir_heads[bkt];
        dir_sizes[e]  = rs;
        dir_counts[e] = rc;
        dir_offs[e]   = 31'(64'(dir_used) + ENTRY_HDR);
        dir_heads[bkt] = 7'(e + 1);
        dir_tables = e + 1;
        dir_used = 31'(64'(dir_used) + total);
        o.status = ntd_pkg::ST_OK;
        o.rsize  = rs;
        o.rcount = rc;
        o.offset = dir_offs[e];
      end
    end
    o.used = dir_used;
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Accepted input transactions: predict and queue
  always @(posedge clk) begin
    outcome_t o;
    if (!rst && s_tvalid && s_tready) begin
      o = dir_apply(s_tuser, s_tdata[255:0], s_tdata[271:256], s_tdata[287:272]);
      if (cur_fixed) begin
        o.status = cur_status;
        o.used   = cur_used;
        if (cur_status != ntd_pkg::ST_OK && cur_status != ntd_pkg::ST_EXISTS) begin
          o.rsize = '0; o.rcount = '0; o.offset = '0;
        end
      end
      dir_pending.push_back(o);
    end
  end

  // Accepted results: compare against the oldest expectation
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (dir_pending.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        errors++;
      end else begin
        w = dir_pending.pop_front();
        if (m_tdata[2:0] !== w.status)   report("status", m_tdata[2:0], w.status);
        if (m_tdata[18:3] !== w.rsize)   report("record_size", m_tdata[18:3], w.rsize);
        if (m_tdata[34:19] !== w.rcount) report("record_count", m_tdata[34:19], w.rcount);
        if (m_tdata[65:35] !== w.offset) report("data_offset", m_tdata[65:35], w.offset);
        if (m_tdata[96:66] !== w.used)   report("used_bytes", m_tdata[96:66], w.used);
      end
    end
  end

  // Receiver: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic store_size_write(input logic [30:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_STORE_SIZE; pwdata <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dir_store_size = val;
  endtask

  task automatic drain();
    while (dir_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one transaction from the current edge and hold it until taken,
  // with an optional idle gap after
  task automatic send(input row_t r, input bit gaps);
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {r.rcount, r.rsize, r.name};
    cur_fixed <= r.fixed; cur_status <= r.status; cur_used <= r.used;
    do @(posedge clk); while (!s_tready);
    if (gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic row_t mk(input logic cmd, input logic [255:0] nm, input int rs,
                              input int rc, input bit fx = 0, input logic [2:0] st = '0,
                              input int used = 0);
    row_t r;
    r.cmd = cmd; r.name = nm; r.rsize = 16'(rs); r.rcount = 16'(rc);
    r.fixed = fx; r.status = st; r.used = 31'(used);
    return r;
  endfunction

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3, 4:    return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  // Random item: mostly pool names, some with garbage past the terminator, some pure noise
  function automatic row_t rand_item();
    logic [255:0] nm;
    int len;
    nm = pool[$urandom_range(0, POOL_N-1)];
    if ($urandom_range(0, 6) == 0) begin
      for (int i = 0; i < 8; i++) nm[i*32 +: 32] = $urandom;
    end else if ($urandom_range(0, 2) == 0) begin
      len = 31;
      for (int i = 0; i < 31; i++)
        if (nm[i*8 +: 8] == 8'd0) begin
          len = i;
          break;
        end
      for (int i = len + 1; i < 32; i++) nm[i*8 +: 8] = 8'($urandom);
      if (len == 31) nm[255:248] = 8'($urandom);
    end
    return mk(1'($urandom_range(0, 1)), nm, rand_dim(), rand_dim());
  endfunction

  task automatic random_phase(input int n, input bit gaps);
    for (int k = 0; k < n; k++) send(rand_item(), gaps);
    s_tvalid <= 1'b0;
  endtask

  initial begin
    logic [255:0] a_name, coll, k1, k2;
    int a_bkt;
    dir_store_size = ntd_pkg::STORE_RESET;
    foreach (dir_heads[i]) dir_heads[i] = '0;
    dir_tables = 0;
    dir_used = 31'(HEAD_SIZE);

    // Name pool, lengths 1..31
    foreach (pool[p]) begin
      pool[p] = '0;
      for (int i = 0; i < $urandom_range(1, 31); i++)
        pool[p][i*8 +: 8] = 8'($urandom_range(1, 255));
    end
    pool[0] = {256{1'b1}};

    // A two-byte name sharing a bucket with "a"
    a_name = 256'h61;
    a_bkt = name_bucket(a_name, k1);
    coll = '0;
    for (int x = 1; x < 65536; x++) begin
      k2 = {240'd0, 16'(x)};
      if (k2[7:0] != 0 && k2[15:8] != 0 && name_bucket(k2, k1) == a_bkt) begin
        coll = k2;
        break;
      end
    end
    pool[1] = coll;
    pool[2] = a_name;

    // Directed table: lookup on empty, invalid sizes, no space, hits, aliases
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, a_name, 0, 0, 1, ntd_pkg::ST_NOT_FOUND,
                          HEAD_SIZE));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, a_name, 0, 5, 1, ntd_pkg::ST_INVALID,
                          HEAD_SIZE));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, a_name, 5, 0, 1, ntd_pkg::ST_INVALID,
                          HEAD_SIZE));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, a_name, 65535, 65535, 1,
                          ntd_pkg::ST_NO_SPACE, HEAD_SIZE));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, a_name, 1, 1));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, a_name, 2, 2));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, a_name, 0, 0));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, coll, 0, 0));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, coll, 7, 9));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, coll, 0, 0));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, a_name, 0, 0));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, '0, 3, 3));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, '0, 65535, 65535));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, {256{1'b1}}, 65535, 1));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, {8'h00, {248{1'b1}}}, 0, 0));
    directed.push_back(mk(ntd_pkg::CMD_LOOKUP, {{192{1'b1}}, 64'hFFFF_FF00_0000_0061},
                          0, 0));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, {8'h5A, {248{1'b1}}}, 1, 65535));
    directed.push_back(mk(ntd_pkg::CMD_INSERT, 256'h62, 65535, 15));

    // Reset
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send(directed[i], 1'b0);
    s_tvalid <= 1'b0;
    drain();

    store_size_write(31'd4096);
    random_phase(400, 1'b1);
    drain();
    store_size_write(31'h7FFF_FFFF);
    hold_req <= 1'b1;
    random_phase(600, 1'b1);
    drain();
    store_size_write(31'd256);
    random_phase(300, 1'b1);
    drain();
    store_size_write(ntd_pkg::STORE_RESET);
    random_phase(400, 1'b1);
    quiet <= 1'b1;
    random_phase(300, 1'b0);

    // Wait out the remaining results
    while (dir_pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
